// File: src/lzo_pkg.sv
// Shared constants for the LZO1X stream decoder.
`timescale 1ns / 1ps
package lzo_pkg;

    // Decode phases.
    localparam logic [3:0] PH_FIRST       = 4'd0;
    localparam logic [3:0] PH_TOP         = 4'd1;
    localparam logic [3:0] PH_AFTER_LIT   = 4'd2;
    localparam logic [3:0] PH_AFTER_MATCH = 4'd3;
    localparam logic [3:0] PH_LIT_RUN     = 4'd4;
    localparam logic [3:0] PH_LIT_TRAIL   = 4'd5;
    localparam logic [3:0] PH_RUN         = 4'd6;
    localparam logic [3:0] PH_OFF1        = 4'd7;
    localparam logic [3:0] PH_OFF1_FAR    = 4'd8;
    localparam logic [3:0] PH_OFF2A       = 4'd9;
    localparam logic [3:0] PH_OFF2B       = 4'd10;
    localparam logic [3:0] PH_COPY        = 4'd11;
    localparam logic [3:0] PH_ENDED       = 4'd12;

    // Stream status codes.
    localparam logic [2:0] ST_RUNNING  = 3'd0;
    localparam logic [2:0] ST_DONE     = 3'd1;
    localparam logic [2:0] ST_SHORT    = 3'd2;
    localparam logic [2:0] ST_DIST     = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;
    localparam logic [2:0] ST_LENGTH   = 3'd5;
    localparam logic [2:0] ST_RUN      = 3'd6;
    localparam logic [2:0] ST_PENDING  = 3'd7;

    // Input item opcodes.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_PUMP = 1'b1;

    // Format constants.
    localparam logic [7:0]  FIRST_LIT_BIAS = 8'd17;
    localparam logic [16:0] M2_REACH       = 17'h00800;
    localparam logic [16:0] M4_BASE        = 17'h04000;
    localparam logic [32:0] RUN_STEP       = 33'd255;
    localparam logic [32:0] M3_BASE_LEN    = 33'd31;
    localparam logic [32:0] M4_BASE_LEN    = 33'd7;
    localparam logic [32:0] LIT_BASE_LEN   = 33'd15;

    // Where the byte of a stage-one item comes from.
    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_LIT,
        SRC_RAM,
        SRC_FWD
    } byte_src_t;

endpackage

// File: src/lzo_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module lzo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/lzo1x_stream_decoder_top.sv
// Top level of the LZO1X stream decoder with its history memory.
`timescale 1ns / 1ps
// Takes one item per clock cycle, sustained: a compressed byte or a pump item
// that copies one byte of a pending match out of the history memory. Every
// item yields one result, which passes through stage one, where the registered
// read of the history memory completes, and then the result register; a byte
// written by the item just ahead is forwarded so that overlapping copies run at full rate.
// in_ready drops only while the result register is held by res_ready low.
// The history memory needs no clearing; it is read only at positions that
// the current stream has already written.
module lzo1x_stream_decoder_top #(
    parameter int          HISTORY_DEPTH = 65536,
    parameter logic [31:0] RUN_LIMIT     = 32'd1073741824
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [7:0]  out_byte,
    output logic        out_valid,
    output logic        copy_pending,
    output logic [2:0]  status
);
    import lzo_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);

    // Decoder state.
    logic [31:0] cap_reg;
    logic [3:0]  phase_reg, phase_next;
    logic [31:0] len_reg, len_next;
    logic [15:0] dist_reg, dist_next;
    logic [7:0]  instr_reg, instr_next;
    logic [7:0]  offlo_reg, offlo_next;
    logic [1:0]  trail_reg, trail_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [2:0]  st_reg, st_next;

    // Stage one and result register.
    logic        s1_v_reg;
    byte_src_t   s1_src_reg, s1_src_next;
    logic [7:0]  s1_data_reg, s1_data_next;
    logic [AW-1:0] s1_waddr_reg;
    logic        s1_cp_reg, s1_cp_next;
    logic [2:0]  s1_st_reg, s1_st_next;
    logic        o_v_reg;
    logic [7:0]  o_byte_reg;
    logic        o_ov_reg;
    logic        o_cp_reg;
    logic [2:0]  o_st_reg;

    logic        accept;
    logic        advance;
    logic [7:0]  s1_byte;
    logic        s1_wen;
    logic [7:0]  ram_rdata;
    logic [AW-1:0] rd_addr;
    logic        rd_en;

    assign advance  = !o_v_reg || res_ready;
    assign in_ready = !s1_v_reg || advance;
    assign accept   = in_valid && in_ready;
    assign s1_wen   = (s1_src_reg != SRC_NONE);

    // Byte carried by stage one.
    always_comb
    begin
        case (s1_src_reg)
            SRC_RAM: s1_byte = ram_rdata;
            SRC_LIT: s1_byte = s1_data_reg;
            SRC_FWD: s1_byte = s1_data_reg;
            default: s1_byte = 8'd0;
        endcase
    end

    lzo_ram #(
        .WIDTH(8),
        .DEPTH(HISTORY_DEPTH)
    ) u_history (
        .clk  (clk),
        .we   (s1_v_reg && advance && s1_wen),
        .waddr(s1_waddr_reg),
        .wdata(s1_byte),
        .re   (rd_en),
        .raddr(rd_addr),
        .rdata(ram_rdata)
    );

    // Next decoder state for the item at the input.
    always_comb
    begin
        logic [32:0] room;
        logic [32:0] room1;
        logic [31:0] cnt1;
        logic        dsp;
        logic [3:0]  ctx;
        logic        bl_do;
        logic [32:0] bl_n;
        logic [3:0]  bl_phase;
        logic        bm_do;
        logic [16:0] bm_back;
        logic [32:0] bm_len;
        logic [7:0]  bm_trail;
        logic [4:0]  t;
        logic [13:0] extra;
        logic [16:0] hi;
        logic [2:0]  fail_code;
        logic        do_fail;
        logic        emit_lit;
        logic        emit_pump;

        cnt1      = cnt_reg + 32'd1;
        room      = (cnt_reg >= cap_reg) ? 33'd0 : {1'b0, cap_reg} - {1'b0, cnt_reg};
        room1     = (cnt1 >= cap_reg) ? 33'd0 : {1'b0, cap_reg} - {1'b0, cnt1};
        dsp       = 1'b0;
        ctx       = phase_reg;
        bl_do     = 1'b0;
        bl_n      = 33'd0;
        bl_phase  = PH_LIT_RUN;
        bm_do     = 1'b0;
        bm_back   = 17'd0;
        bm_len    = 33'd0;
        bm_trail  = 8'd0;
        t         = 5'd0;
        extra     = 14'd0;
        hi        = 17'd0;
        fail_code = ST_RUNNING;
        do_fail   = 1'b0;
        emit_lit  = 1'b0;
        emit_pump = 1'b0;

        phase_next = phase_reg;
        len_next   = len_reg;
        dist_next  = dist_reg;
        instr_next = instr_reg;
        offlo_next = offlo_reg;
        trail_next = trail_reg;
        cnt_next   = cnt_reg;
        st_next    = st_reg;
        rd_addr    = cnt_reg[AW-1:0] - AW'(dist_reg);

        if (opcode == OP_PUMP)
        begin
            // One byte of a pending match.
            if (phase_reg == PH_COPY)
            begin
                emit_pump = 1'b1;
                cnt_next  = cnt1;
                len_next  = len_reg - 32'd1;
                if (len_reg == 32'd1)
                begin
                    if (trail_reg == 2'd0)
                    begin
                        phase_next = PH_TOP;
                    end
                    else if ({31'd0, trail_reg} > room1)
                    begin
                        do_fail   = 1'b1;
                        fail_code = ST_OVERFLOW;
                    end
                    else
                    begin
                        len_next   = {30'd0, trail_reg};
                        phase_next = PH_LIT_TRAIL;
                    end
                end
            end
        end
        else if (phase_reg != PH_ENDED)
        begin
            // Compressed byte.
            case (phase_reg)
                PH_FIRST:
                begin
                    if (in_byte > FIRST_LIT_BIAS)
                    begin
                        bl_do    = 1'b1;
                        bl_n     = {25'd0, in_byte - FIRST_LIT_BIAS};
                        bl_phase = (bl_n < 33'd4) ? PH_LIT_TRAIL : PH_LIT_RUN;
                    end
                    else
                    begin
                        dsp = 1'b1;
                        ctx = PH_TOP;
                    end
                end
                PH_TOP, PH_AFTER_LIT, PH_AFTER_MATCH:
                begin
                    dsp = 1'b1;
                end
                PH_LIT_RUN, PH_LIT_TRAIL:
                begin
                    emit_lit = 1'b1;
                    cnt_next = cnt1;
                    len_next = len_reg - 32'd1;
                    if (len_reg == 32'd1)
                    begin
                        phase_next = (phase_reg == PH_LIT_RUN) ? PH_AFTER_LIT
                                                               : PH_AFTER_MATCH;
                    end
                end
                PH_RUN:
                begin
                    if (in_byte == 8'd0)
                    begin
                        if (len_reg > RUN_LIMIT)
                        begin
                            do_fail   = 1'b1;
                            fail_code = ST_RUN;
                        end
                        else
                        begin
                            len_next = len_reg + RUN_STEP[31:0];
                        end
                    end
                    else if (instr_reg < 8'd16)
                    begin
                        bl_do    = 1'b1;
                        bl_n     = {1'b0, len_reg} + LIT_BASE_LEN + {25'd0, in_byte} + 33'd3;
                        bl_phase = PH_LIT_RUN;
                    end
                    else
                    begin
                        len_next = len_reg
                                 + ((instr_reg >= 8'd32) ? M3_BASE_LEN[31:0] : M4_BASE_LEN[31:0])
                                 + {24'd0, in_byte} + 32'd2;
                        phase_next = PH_OFF2A;
                    end
                end
                PH_OFF1:
                begin
                    bm_do    = 1'b1;
                    bm_trail = instr_reg;
                    if (instr_reg >= 8'd64)
                    begin
                        bm_back = 17'd1 + {14'd0, instr_reg[4:2]} + {6'd0, in_byte, 3'd0};
                        bm_len  = {30'd0, instr_reg[7:5]} + 33'd1;
                    end
                    else
                    begin
                        bm_back = 17'd1 + {11'd0, instr_reg[7:2]} + {7'd0, in_byte, 2'd0};
                        bm_len  = 33'd2;
                    end
                end
                PH_OFF1_FAR:
                begin
                    bm_do    = 1'b1;
                    bm_trail = instr_reg;
                    bm_back  = 17'd1 + M2_REACH + {11'd0, instr_reg[7:2]}
                             + {7'd0, in_byte, 2'd0};
                    bm_len   = 33'd3;
                end
                PH_OFF2A:
                begin
                    offlo_next = in_byte;
                    phase_next = PH_OFF2B;
                end
                PH_OFF2B:
                begin
                    extra = {8'd0, offlo_reg[7:2]} + {in_byte, 6'd0};
                    if (instr_reg >= 8'd32)
                    begin
                        bm_do    = 1'b1;
                        bm_back  = 17'd1 + {3'd0, extra};
                        bm_len   = {1'b0, len_reg};
                        bm_trail = offlo_reg;
                    end
                    else
                    begin
                        hi = {2'd0, instr_reg[3], 14'd0};
                        if (hi == 17'd0 && extra == 14'd0)
                        begin
                            do_fail   = 1'b1;
                            fail_code = (cap_reg != 32'd0 && cnt_reg == cap_reg) ? ST_DONE
                                                                                 : ST_LENGTH;
                        end
                        else
                        begin
                            bm_do    = 1'b1;
                            bm_back  = hi + {3'd0, extra} + M4_BASE;
                            bm_len   = {1'b0, len_reg};
                            bm_trail = offlo_reg;
                        end
                    end
                end
                default:
                begin
                    do_fail   = 1'b1;
                    fail_code = ST_PENDING;
                end
            endcase

            // Instruction dispatch from a top-level phase.
            if (dsp)
            begin
                instr_next = in_byte;
                t = (in_byte >= 8'd32) ? in_byte[4:0] : {2'd0, in_byte[2:0]};
                if (in_byte >= 8'd64)
                begin
                    phase_next = PH_OFF1;
                end
                else if (in_byte >= 8'd16)
                begin
                    if (t == 5'd0)
                    begin
                        len_next   = 32'd0;
                        phase_next = PH_RUN;
                    end
                    else
                    begin
                        len_next   = {27'd0, t} + 32'd2;
                        phase_next = PH_OFF2A;
                    end
                end
                else if (ctx == PH_TOP)
                begin
                    if (in_byte == 8'd0)
                    begin
                        len_next   = 32'd0;
                        phase_next = PH_RUN;
                    end
                    else
                    begin
                        bl_do    = 1'b1;
                        bl_n     = {25'd0, in_byte} + 33'd3;
                        bl_phase = PH_LIT_RUN;
                    end
                end
                else if (ctx == PH_AFTER_LIT)
                begin
                    phase_next = PH_OFF1_FAR;
                end
                else
                begin
                    phase_next = PH_OFF1;
                end
            end

            // Start of a literal run.
            if (bl_do)
            begin
                if (bl_n > room)
                begin
                    do_fail   = 1'b1;
                    fail_code = ST_OVERFLOW;
                end
                else
                begin
                    len_next   = bl_n[31:0];
                    phase_next = bl_phase;
                end
            end

            // Start of a match copy.
            if (bm_do)
            begin
                if ({15'd0, bm_back} > cnt_reg)
                begin
                    do_fail   = 1'b1;
                    fail_code = ST_DIST;
                end
                else if (bm_len > room)
                begin
                    do_fail   = 1'b1;
                    fail_code = ST_OVERFLOW;
                end
                else
                begin
                    dist_next  = bm_back[15:0];
                    len_next   = bm_len[31:0];
                    trail_next = bm_trail[1:0];
                    phase_next = PH_COPY;
                end
            end
        end

        if (do_fail)
        begin
            st_next    = fail_code;
            phase_next = PH_ENDED;
        end

        // A last byte that leaves the stream running is a short input.
        if (opcode == OP_BYTE && in_last && st_next == ST_RUNNING)
        begin
            st_next    = ST_SHORT;
            phase_next = PH_ENDED;
        end

        // Result fields for stage one.
        s1_st_next = st_next;
        s1_cp_next = (phase_next == PH_COPY);
        if (emit_pump)
        begin
            if (s1_v_reg && s1_wen && s1_waddr_reg == rd_addr)
            begin
                s1_src_next  = SRC_FWD;
                s1_data_next = s1_byte;
            end
            else
            begin
                s1_src_next  = SRC_RAM;
                s1_data_next = in_byte;
            end
        end
        else if (emit_lit)
        begin
            s1_src_next  = SRC_LIT;
            s1_data_next = in_byte;
        end
        else
        begin
            s1_src_next  = SRC_NONE;
            s1_data_next = in_byte;
        end
        rd_en = accept && emit_pump;

        // Rearm after the last byte of a stream.
        if (opcode == OP_BYTE && in_last)
        begin
            phase_next = PH_FIRST;
            len_next   = 32'd0;
            dist_next  = 16'd0;
            instr_next = 8'd0;
            offlo_next = 8'd0;
            trail_next = 2'd0;
            cnt_next   = 32'd0;
            st_next    = ST_RUNNING;
            s1_cp_next = 1'b0;
        end
    end

    // Decoder state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= 32'd65536;
            phase_reg <= PH_FIRST;
            len_reg   <= 32'd0;
            dist_reg  <= 16'd0;
            instr_reg <= 8'd0;
            offlo_reg <= 8'd0;
            trail_reg <= 2'd0;
            cnt_reg   <= 32'd0;
            st_reg    <= ST_RUNNING;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                len_reg   <= len_next;
                dist_reg  <= dist_next;
                instr_reg <= instr_next;
                offlo_reg <= offlo_next;
                trail_reg <= trail_next;
                cnt_reg   <= cnt_next;
                st_reg    <= st_next;
            end
        end
    end

    // Stage one and result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_v_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_v_reg <= 1'b0;
            end
            if (advance)
            begin
                o_v_reg <= s1_v_reg;
            end
        end
    end

    // Stage one and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_src_reg   <= s1_src_next;
            s1_data_reg  <= s1_data_next;
            s1_waddr_reg <= cnt_reg[AW-1:0];
            s1_cp_reg    <= s1_cp_next;
            s1_st_reg    <= s1_st_next;
        end
        if (advance && s1_v_reg)
        begin
            o_byte_reg <= s1_byte;
            o_ov_reg   <= s1_wen;
            o_cp_reg   <= s1_cp_reg;
            o_st_reg   <= s1_st_reg;
        end
    end

    assign res_valid    = o_v_reg;
    assign out_byte     = o_byte_reg;
    assign out_valid    = o_ov_reg;
    assign copy_pending = o_cp_reg;
    assign status       = o_st_reg;

    // A result without a produced byte carries a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !out_valid |-> out_byte == 8'd0)
        else $error("result byte not zero without a produced byte");

    // A pending copy only exists in a running stream.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && copy_pending |-> status == ST_RUNNING)
        else $error("copy pending in an ended stream");

    // The output count steps by at most one per item, or clears on rearm.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (cnt_reg == $past(cnt_reg) + 32'd1) || (cnt_reg == $past(cnt_reg))
                   || (cnt_reg == 32'd0))
        else $error("output count jumped");

endmodule

// File: tb/sv/tb_lzo1x_stream_decoder_top.sv
// Self-checking testbench for the LZO1X stream decoder top level.
`timescale 1ns / 1ps
module tb_lzo1x_stream_decoder_top;
    import lzo_pkg::*;

    // One result item of the decoder.
    typedef struct packed {
        logic [7:0] obyte;
        logic       ovalid;
        logic       pend;
        logic [2:0] stat;
    } dec_res_t;

    // One directed stimulus row; typed rows carry their own expectation.
    typedef struct packed {
        logic       op;
        logic [7:0] b;
        logic       last;
        logic       typed;
        dec_res_t   res;
    } stim_row_t;

    localparam int unsigned RUN_CAP = 32'd1073741824;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic        opcode;
    logic [7:0]  in_byte;
    logic        in_last;
    logic        res_valid;
    logic        res_ready;
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        copy_pending;
    logic [2:0]  status;

    lzo1x_stream_decoder_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .out_byte     (out_byte),
        .out_valid    (out_valid),
        .copy_pending (copy_pending),
        .status       (status)
    );

    // Decoder model state.
    logic [7:0]  hist [0:65535];
    logic [31:0] cap_reg;
    logic [3:0]  phase;
    logic [31:0] len_acc;
    logic [15:0] back_dist;
    logic [7:0]  instr;
    logic [7:0]  off_lo;
    logic [1:0]  trail;
    logic [31:0] ocount;
    logic [2:0]  sstat;
    logic [7:0]  emit_b;
    logic        emit_v;

    dec_res_t    expected_q [$];
    int          mismatches = 0;
    int          items_sent = 0;
    bit          no_idle = 1'b0;
    bit          pressure_done = 1'b0;

    // Stream shaping state for the random part.
    int unsigned target_len;
    bit          end_pending;

    // Clock.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Overall time limit.
    initial
    begin
        #20_000_000;
        $display("lzo1x_stream_decoder_top verification failed");
        $finish;
    end

    function automatic longint unsigned room_left();
        return (ocount >= cap_reg) ? 0 : longint'(cap_reg) - longint'(ocount);
    endfunction

    task automatic end_stream(input logic [2:0] code);
        sstat = code;
        phase = PH_ENDED;
    endtask

    task automatic rearm();
        phase = PH_FIRST;
        len_acc = '0;
        back_dist = '0;
        instr = '0;
        off_lo = '0;
        trail = '0;
        ocount = '0;
        sstat = ST_RUNNING;
    endtask

    task automatic start_literals(input longint unsigned n, input logic [3:0] ph);
        if (n > room_left())
        begin
            end_stream(ST_OVERFLOW);
        end
        else
        begin
            len_acc = n[31:0];
            phase = ph;
        end
    endtask

    task automatic start_copy(input logic [31:0] back, input longint unsigned n,
                              input logic [7:0] tr);
        if (back > ocount)
        begin
            end_stream(ST_DIST);
        end
        else if (n > room_left())
        begin
            end_stream(ST_OVERFLOW);
        end
        else
        begin
            back_dist = back[15:0];
            len_acc = n[31:0];
            trail = tr[1:0];
            phase = PH_COPY;
        end
    endtask

    task automatic emit(input logic [7:0] v);
        hist[ocount[15:0]] = v;
        ocount = ocount + 1;
        emit_b = v;
        emit_v = 1'b1;
    endtask

    // Instruction byte seen in one of the instruction phases.
    task automatic decode_instr(input logic [7:0] b, input logic [3:0] ctx);
        logic [31:0] t;
        instr = b;
        if (b >= 64)
        begin
            phase = PH_OFF1;
        end
        else if (b >= 16)
        begin
            t = (b >= 32) ? (b & 31) : (b & 7);
            if (t == 0)
            begin
                len_acc = 0;
                phase = PH_RUN;
            end
            else
            begin
                len_acc = t + 2;
                phase = PH_OFF2A;
            end
        end
        else if (ctx == PH_TOP)
        begin
            if (b == 0)
            begin
                len_acc = 0;
                phase = PH_RUN;
            end
            else
            begin
                start_literals(longint'(b) + 3, PH_LIT_RUN);
            end
        end
        else if (ctx == PH_AFTER_LIT)
        begin
            phase = PH_OFF1_FAR;
        end
        else
        begin
            phase = PH_OFF1;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic [31:0] t;
        logic [31:0] extra;
        logic [31:0] hi;
        logic [31:0] base;
        case (phase)
            PH_FIRST:
            begin
                if (b > FIRST_LIT_BIAS)
                begin
                    t = b - FIRST_LIT_BIAS;
                    start_literals(t, (t < 4) ? PH_LIT_TRAIL : PH_LIT_RUN);
                end
                else
                begin
                    decode_instr(b, PH_TOP);
                end
            end
            PH_TOP, PH_AFTER_LIT, PH_AFTER_MATCH:
                decode_instr(b, phase);
            PH_LIT_RUN, PH_LIT_TRAIL:
            begin
                emit(b);
                len_acc = len_acc - 1;
                if (len_acc == 0)
                    phase = (phase == PH_LIT_RUN) ? PH_AFTER_LIT : PH_AFTER_MATCH;
            end
            PH_RUN:
            begin
                if (b == 0)
                begin
                    if (len_acc > RUN_CAP)
                        end_stream(ST_RUN);
                    else
                        len_acc = len_acc + 255;
                end
                else if (instr < 16)
                begin
                    start_literals(longint'(len_acc) + 15 + b + 3, PH_LIT_RUN);
                end
                else
                begin
                    base = (instr >= 32) ? 31 : 7;
                    len_acc = len_acc + base + b + 2;
                    phase = PH_OFF2A;
                end
            end
            PH_OFF1:
            begin
                if (instr >= 64)
                    start_copy(1 + ((instr >> 2) & 7) + (32'(b) << 3),
                               (instr >> 5) + 1, instr);
                else
                    start_copy(1 + (instr >> 2) + (32'(b) << 2), 2, instr);
            end
            PH_OFF1_FAR:
                start_copy(1 + 32'h800 + (instr >> 2) + (32'(b) << 2), 3, instr);
            PH_OFF2A:
            begin
                off_lo = b;
                phase = PH_OFF2B;
            end
            PH_OFF2B:
            begin
                extra = (32'(off_lo) >> 2) + (32'(b) << 6);
                if (instr >= 32)
                begin
                    start_copy(1 + extra, len_acc, off_lo);
                end
                else
                begin
                    hi = (32'(instr) & 8) << 11;
                    if (hi == 0 && extra == 0)
                        end_stream((cap_reg != 0 && ocount == cap_reg) ? ST_DONE
                                                                       : ST_LENGTH);
                    else
                        start_copy(hi + extra + 32'h4000, len_acc, off_lo);
                end
            end
            default:
                end_stream(ST_PENDING);
        endcase
    endtask

    // Works out the result of one item and advances the model.
    task automatic predict_result(input logic op, input logic [7:0] b, input logic last,
                                  output dec_res_t r);
        logic [31:0] pos;
        logic [2:0]  st;
        emit_b = 8'd0;
        emit_v = 1'b0;
        if (op == OP_PUMP)
        begin
            if (phase == PH_COPY)
            begin
                pos = ocount - back_dist;
                emit(hist[pos[15:0]]);
                len_acc = len_acc - 1;
                if (len_acc == 0)
                begin
                    if (trail == 0)
                        phase = PH_TOP;
                    else
                        start_literals(trail, PH_LIT_TRAIL);
                end
            end
            st = sstat;
        end
        else
        begin
            if (phase != PH_ENDED)
                decode_byte(b);
            if (last && sstat == ST_RUNNING)
                end_stream(ST_SHORT);
            st = sstat;
            if (last)
                rearm();
        end
        r.obyte = emit_b;
        r.ovalid = emit_v;
        r.pend = (phase == PH_COPY);
        r.stat = st;
    endtask

    // Offers one item and waits until it is accepted.
    task automatic send_item(input logic op, input logic [7:0] b, input logic last,
                             input logic typed, input dec_res_t tres);
        dec_res_t pr;
        int gap;
        predict_result(op, b, last, pr);
        expected_q.push_back(typed ? tres : pr);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        opcode <= op;
        in_byte <= b;
        in_last <= last;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    // Writes the capacity register once the decoder has drained.
    task automatic write_capacity(input logic [31:0] v);
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        cap_reg = v;
    endtask

    // Picks the next item of a mostly well-formed stream from the model state.
    task automatic next_stream_item(output logic op, output logic [7:0] b,
                                    output logic last);
        longint rm;
        longint lim;
        int r;
        op = OP_BYTE;
        b = 8'($urandom_range(0, 255));
        last = 1'b0;
        rm = longint'(target_len) - longint'(ocount);
        case (phase)
            PH_COPY:
            begin
                r = $urandom_range(0, 99);
                if (r < 97)
                    op = OP_PUMP;
                else
                    last = ($urandom_range(0, 3) == 0);
            end
            PH_ENDED:
                last = ($urandom_range(0, 2) == 0);
            PH_FIRST:
            begin
                if ($urandom_range(0, 7) == 0 || rm < 1)
                    b = 8'($urandom_range(0, 17));
                else
                    b = 8'(17 + $urandom_range(1, (rm > 20) ? 20 : rm));
            end
            PH_TOP, PH_AFTER_LIT, PH_AFTER_MATCH:
            begin
                r = $urandom_range(0, 9);
                if (rm <= 0 || end_pending)
                begin
                    end_pending = 1'b1;
                    b = 8'h11;
                end
                else if (r < 4)
                begin
                    b = {(rm >= 8) ? 3'($urandom_range(2, 7)) : 3'd2,
                         3'($urandom_range(0, 7)),
                         (rm >= 12) ? 2'($urandom_range(0, 3)) : 2'd0};
                end
                else if (r < 6)
                begin
                    b = 8'h20 | 8'($urandom_range(0, (rm > 33) ? 31
                                                  : ((rm > 3) ? rm - 2 : 1)));
                end
                else if (r < 9)
                begin
                    b = 8'($urandom_range(0, 15));
                end
                else
                begin
                    last = ($urandom_range(0, 7) == 0);
                end
            end
            PH_LIT_RUN, PH_LIT_TRAIL:
                last = ($urandom_range(0, 199) == 0);
            PH_RUN:
            begin
                if ($urandom_range(0, 7) == 0)
                    b = 8'd0;
                else
                    b = 8'($urandom_range(1, 255));
            end
            PH_OFF1:
            begin
                if (instr >= 64)
                    lim = (longint'(ocount) - 1 - ((instr >> 2) & 7)) >>> 3;
                else
                    lim = (longint'(ocount) - 1 - (instr >> 2)) >>> 2;
                if (lim >= 0 && $urandom_range(0, 9) != 0)
                    b = 8'($urandom_range(0, (lim > 255) ? 255 : lim));
            end
            PH_OFF2A:
            begin
                if (end_pending)
                    b = 8'd0;
            end
            PH_OFF2B:
            begin
                if (end_pending)
                begin
                    b = 8'd0;
                    last = 1'b1;
                    end_pending = 1'b0;
                end
                else if (instr >= 32)
                begin
                    lim = (longint'(ocount) - 1 - (off_lo >> 2)) >>> 6;
                    if (lim >= 0 && $urandom_range(0, 9) != 0)
                        b = 8'($urandom_range(0, (lim > 255) ? 255 : lim));
                end
            end
            default:
                ;
        endcase
    endtask

    // Result monitor.
    always @(posedge clk)
    begin
        dec_res_t exp_r;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: byte %h valid %b pend %b status %0d",
                             out_byte, out_valid, copy_pending, status);
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (out_byte !== exp_r.obyte || out_valid !== exp_r.ovalid ||
                    copy_pending !== exp_r.pend || status !== exp_r.stat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected byte %h valid %b pend %b status %0d,",
                                  " got %h %b %b %0d"},
                                 exp_r.obyte, exp_r.ovalid, exp_r.pend, exp_r.stat,
                                 out_byte, out_valid, copy_pending, status);
                end
            end
        end
    end

    // Receiver: random stalls, one long hold-off, none near the end.
    initial
    begin
        int n;
        res_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!pressure_done && items_sent > 300)
            begin
                res_ready <= 1'b0;
                pressure_done = 1'b1;
                repeat (300) @(negedge clk);
                res_ready <= 1'b1;
            end
            else if (no_idle)
            begin
                res_ready <= 1'b1;
            end
            else
            begin
                res_ready <= ($urandom_range(0, 2) != 0);
                n = $urandom_range(1, 16);
                repeat (n - 1) @(negedge clk);
            end
        end
    end

    // Directed rows, then random streams.
    initial
    begin
        stim_row_t rows [22];
        dec_res_t  zero_r;
        logic        op;
        logic [7:0]  b;
        logic        last;
        int          stream_no;
        int          stream_items;
        logic [31:0] cap_v;

        zero_r = '0;
        rows[0]  = '{OP_BYTE, 8'h12, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, ST_RUNNING}};
        rows[1]  = '{OP_BYTE, 8'hAA, 1'b0, 1'b1, '{8'hAA, 1'b1, 1'b0, ST_RUNNING}};
        rows[2]  = '{OP_PUMP, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, ST_RUNNING}};
        rows[3]  = '{OP_BYTE, 8'h11, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, ST_RUNNING}};
        rows[4]  = '{OP_BYTE, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, ST_RUNNING}};
        rows[5]  = '{OP_BYTE, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, ST_LENGTH}};
        rows[6]  = '{OP_BYTE, 8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, ST_SHORT}};
        rows[7]  = '{OP_BYTE, 8'h12, 1'b0, 1'b0, zero_r};
        rows[8]  = '{OP_BYTE, 8'h55, 1'b0, 1'b0, zero_r};
        rows[9]  = '{OP_BYTE, 8'h40, 1'b0, 1'b0, zero_r};
        rows[10] = '{OP_BYTE, 8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, ST_DIST}};
        rows[11] = '{OP_BYTE, 8'h15, 1'b0, 1'b0, zero_r};
        rows[12] = '{OP_BYTE, 8'h00, 1'b0, 1'b0, zero_r};
        rows[13] = '{OP_BYTE, 8'hFF, 1'b0, 1'b0, zero_r};
        rows[14] = '{OP_BYTE, 8'h01, 1'b0, 1'b0, zero_r};
        rows[15] = '{OP_BYTE, 8'h80, 1'b0, 1'b0, zero_r};
        rows[16] = '{OP_BYTE, 8'h40, 1'b0, 1'b0, zero_r};
        rows[17] = '{OP_BYTE, 8'h00, 1'b0, 1'b0, zero_r};
        rows[18] = '{OP_PUMP, 8'h00, 1'b0, 1'b0, zero_r};
        rows[19] = '{OP_BYTE, 8'h77, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, ST_PENDING}};
        rows[20] = '{OP_BYTE, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, ST_PENDING}};
        rows[21] = '{OP_PUMP, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, ST_RUNNING}};

        // Reset and idle inputs.
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        opcode = OP_BYTE;
        in_byte = '0;
        in_last = 1'b0;
        cap_reg = 32'd65536;
        rearm();
        end_pending = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset capacity.
        foreach (rows[i])
            send_item(rows[i].op, rows[i].b, rows[i].last, rows[i].typed, rows[i].res);

        // Random streams, with the capacity changed every few streams.
        stream_no = 0;
        while (items_sent < 1100)
        begin
            if (stream_no % 6 == 0)
            begin
                case ((stream_no / 6) % 5)
                    0: cap_v = 32'd1;
                    1: cap_v = 32'hFFFF_FFFF;
                    2: cap_v = 32'd65536;
                    default: cap_v = $urandom_range(2, 300);
                endcase
                write_capacity(cap_v);
            end
            target_len = (cap_reg <= 400) ? cap_reg : $urandom_range(1, 300);
            end_pending = 1'b0;
            stream_items = 0;
            last = 1'b0;
            while (!last)
            begin
                if (items_sent > 950)
                    no_idle = 1'b1;
                next_stream_item(op, b, last);
                // The stream is cut short at a byte item once the item budget is spent or the stream passes 1500 items.
                if ((stream_items > 1500 || items_sent >= 1100) && op == OP_BYTE)
                    last = 1'b1;
                send_item(op, b, last, 1'b0, zero_r);
                stream_items++;
            end
            stream_no++;
        end

        // Drain and report.
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("lzo1x_stream_decoder_top verification clean");
        else
            $display("lzo1x_stream_decoder_top verification failed");
        $finish;
    end

endmodule

// File: files.f
src/lzo_pkg.sv
src/lzo_ram.sv
src/lzo1x_stream_decoder_top.sv
tb/sv/tb_lzo1x_stream_decoder_top.sv
